// ===== rtl/bpa_pkg.sv =====
// shared types and codes of the buddy page allocator
`default_nettype none
package bpa_pkg;

    // four-bit order and configuration field
    typedef logic [3:0] ord_t;
    typedef logic [1:0] status_t;

    // result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_INVALID = 2'd1;
    localparam status_t ST_NOMEM   = 2'd2;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // total order after reset
    localparam ord_t TOTAL_ORDER_RST = 4'd13;

endpackage
`default_nettype wire

// ===== rtl/bpa_if.sv =====
// request and response channel interfaces of the buddy page allocator
`default_nettype none
interface bpa_req_if #(parameter int PAGE_BITS = 13);
    import bpa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    ord_t                 req_order;
    logic [PAGE_BITS-1:0] page;
    modport source (output valid, cmd, req_order, page, input ready);
    modport sink (input valid, cmd, req_order, page, output ready);
endinterface

interface bpa_rsp_if #(parameter int PAGE_BITS = 13);
    import bpa_pkg::*;
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [PAGE_BITS-1:0] granted_page;
    logic [PAGE_BITS:0]   free_page_count;
    modport source (output valid, status, granted_page, free_page_count, input ready);
    modport sink (input valid, status, granted_page, free_page_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/buddy_page_allocator_unit.sv =====
// buddy page allocator: fifo free list per order, split on alloc, merge on free
//
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | cmd, req_order, page
//  rsp     | out | valid / ready   | status, granted_page, free_page_count
//  cfg     | in  | cfg_we          | cfg_data (total_order)
//
// alloc: take the head of the lowest non-empty fitting list, then one append per split
// level; invalid order or no memory go straight to the result. free: an append, then per
// merge level a loop step, two list walks visiting one entry at a time, and an append.
// the list walks through the chunk ram read port set the rate.
// after reset or a cfg write the top list is built, one entry a cycle, and req
// is not ready meanwhile.
// one item at a time; a result waiting in the rsp register does not block req.
`default_nettype none
module buddy_page_allocator_unit #(
    parameter int MAX_ORDER_P = 9,
    parameter int PAGE_BITS   = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  bpa_pkg::ord_t cfg_data,
    bpa_req_if.sink       req,
    bpa_rsp_if.source     rsp
);
    import bpa_pkg::*;

    localparam int NORD  = MAX_ORDER_P + 1;
    localparam int OI_W  = $clog2(NORD);
    localparam int SLOTS = 1 << PAGE_BITS;

    typedef logic [PAGE_BITS-1:0] pg_t;
    typedef logic [PAGE_BITS:0]   cnt_t;
    typedef logic [OI_W-1:0]      oi_t;

    localparam cnt_t SLOTS_C = cnt_t'(SLOTS);

    typedef enum logic [3:0] {
        S_INIT_SET, S_INIT_WR, S_IDLE, S_PH_RD, S_PH_USE, S_SPLIT,
        S_FR_LOOP, S_RM_START, S_RM_RD, S_RM_CHK,
        S_AP_REQ, S_AP_WAIT, S_AP_SET, S_DONE
    } state_t;

    state_t  state_reg, ret_reg;
    ord_t    total_order_reg;
    pg_t     head_reg [NORD];
    pg_t     tail_reg [NORD];
    cnt_t    len_reg  [NORD];
    cnt_t    cnt_reg, min_cnt_reg, fpt_reg, k_reg;
    oi_t     a_reg, ord_reg, app_ord_reg;
    pg_t     app_start_reg, page_reg, tgt_reg, cur_reg, prev_reg, slot_reg, granted_reg;
    logic    virgin_reg, pass_reg;
    status_t status_reg;
    logic    out_valid_reg;
    status_t out_status_reg;
    pg_t     out_granted_reg;
    cnt_t    out_fpt_reg;

    // ram ports
    logic st_we, ln_we, pl_we;
    pg_t  st_waddr, st_wdata, ln_waddr, ln_wdata, pl_waddr, pl_wdata;
    pg_t  ck_raddr, pl_raddr;
    pg_t  start_rd, link_rd, pool_rd;

    bpa_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOTS)) u_start_ram (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(ck_raddr), .rdata(start_rd)
    );
    bpa_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOTS)) u_link_ram (
        .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
        .raddr(ck_raddr), .rdata(link_rd)
    );
    bpa_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOTS)) u_pool_ram (
        .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .raddr(pl_raddr), .rdata(pool_rd)
    );

    // buddy of a chunk start at a given order, wrapping in page space
    function automatic pg_t buddy_of(pg_t p, oi_t a);
        logic [PAGE_BITS:0] m;
        pg_t                s;
        m = ((PAGE_BITS+1)'(2) << a) - (PAGE_BITS+1)'(1);
        s = pg_t'(1) << a;
        if ((p & m[PAGE_BITS-1:0]) == '0)
            return p + s;
        return p - s;
    endfunction

    // init figures from the clamped total order
    int unsigned t_cl;
    cnt_t        init_n, init_fpt;
    always_comb
    begin
        t_cl = 32'(total_order_reg);
        if (t_cl < MAX_ORDER_P)
            t_cl = MAX_ORDER_P;
        if (t_cl > PAGE_BITS)
            t_cl = PAGE_BITS;
        init_n   = cnt_t'(1) << (t_cl - MAX_ORDER_P);
        init_fpt = cnt_t'(1) << t_cl;
    end

    // lowest non-empty order at or above the request
    oi_t  req_ord;
    oi_t  fnd_ord;
    logic fnd;
    logic req_bad;
    always_comb
    begin
        req_bad = (32'(req.req_order) > MAX_ORDER_P);
        req_ord = oi_t'(req.req_order);
        fnd     = 1'b0;
        fnd_ord = '0;
        for (int o = NORD - 1; o >= 0; o--)
        begin
            if (o >= 32'(req.req_order) && len_reg[o] != '0)
            begin
                fnd     = 1'b1;
                fnd_ord = oi_t'(o);
            end
        end
    end

    // lookups at the current order cursors
    cnt_t cur_len, app_len;
    pg_t  app_tail, slot_w, idx_dec;
    logic put_ok, hit;
    always_comb
    begin
        cur_len  = len_reg[a_reg];
        app_len  = len_reg[app_ord_reg];
        app_tail = tail_reg[app_ord_reg];
        slot_w   = virgin_reg ? ~cnt_reg[PAGE_BITS-1:0] : pool_rd;
        idx_dec  = cnt_reg[PAGE_BITS-1:0] - pg_t'(1);
        put_ok   = (cnt_reg < SLOTS_C);
        hit      = (start_rd == tgt_reg);
    end

    // ram port control per state
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = slot_reg;
        st_wdata = app_start_reg;
        ln_we    = 1'b0;
        ln_waddr = slot_reg;
        ln_wdata = '0;
        pl_we    = 1'b0;
        pl_waddr = cnt_reg[PAGE_BITS-1:0];
        pl_wdata = cur_reg;
        ck_raddr = cur_reg;
        pl_raddr = idx_dec;
        case (state_reg)
            S_INIT_WR:
            begin
                st_we    = 1'b1;
                st_waddr = k_reg[PAGE_BITS-1:0];
                st_wdata = pg_t'(k_reg[PAGE_BITS-1:0] << MAX_ORDER_P);
                ln_we    = 1'b1;
                ln_waddr = k_reg[PAGE_BITS-1:0];
                ln_wdata = (k_reg + cnt_t'(1) == init_n) ? '0
                                                         : k_reg[PAGE_BITS-1:0] + pg_t'(1);
            end
            S_PH_RD:
            begin
                ck_raddr = head_reg[a_reg];
            end
            S_PH_USE:
            begin
                pl_we    = put_ok;
                pl_wdata = head_reg[a_reg];
            end
            S_AP_WAIT:
            begin
                ln_we    = (app_len != '0);
                ln_waddr = app_tail;
                ln_wdata = slot_w;
            end
            S_AP_SET:
            begin
                st_we = 1'b1;
                ln_we = 1'b1;
            end
            S_RM_CHK:
            begin
                if (hit)
                begin
                    pl_we    = put_ok;
                    ln_we    = (k_reg != '0);
                    ln_waddr = prev_reg;
                    ln_wdata = link_rd;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready           = (state_reg == S_IDLE) && !cfg_we;
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_page    = out_granted_reg;
    assign rsp.free_page_count = out_fpt_reg;

    // sequencer, list registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT_SET;
            ret_reg         <= S_IDLE;
            total_order_reg <= TOTAL_ORDER_RST;
            for (int o = 0; o < NORD; o++)
            begin
                head_reg[o] <= '0;
                tail_reg[o] <= '0;
                len_reg[o]  <= '0;
            end
            cnt_reg         <= '0;
            min_cnt_reg     <= '0;
            fpt_reg         <= '0;
            k_reg           <= '0;
            a_reg           <= '0;
            ord_reg         <= '0;
            app_ord_reg     <= '0;
            app_start_reg   <= '0;
            page_reg        <= '0;
            tgt_reg         <= '0;
            cur_reg         <= '0;
            prev_reg        <= '0;
            slot_reg        <= '0;
            granted_reg     <= '0;
            virgin_reg      <= 1'b0;
            pass_reg        <= 1'b0;
            status_reg      <= ST_OK;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_granted_reg <= '0;
            out_fpt_reg     <= '0;
        end
        else
        begin
            // result register drains independently
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                // build the top order list
                S_INIT_SET:
                begin
                    for (int o = 0; o < NORD; o++)
                    begin
                        head_reg[o] <= '0;
                        tail_reg[o] <= '0;
                        len_reg[o]  <= '0;
                    end
                    len_reg[MAX_ORDER_P]  <= init_n;
                    tail_reg[MAX_ORDER_P] <= init_n[PAGE_BITS-1:0] - pg_t'(1);
                    cnt_reg               <= SLOTS_C - init_n;
                    min_cnt_reg           <= SLOTS_C - init_n;
                    fpt_reg               <= init_fpt;
                    k_reg                 <= '0;
                    state_reg             <= S_INIT_WR;
                end
                S_INIT_WR:
                begin
                    k_reg <= k_reg + cnt_t'(1);
                    if (k_reg + cnt_t'(1) == init_n)
                        state_reg <= S_IDLE;
                end

                // accept an item or a cfg write
                S_IDLE:
                begin
                    if (cfg_we)
                    begin
                        total_order_reg <= cfg_data;
                        state_reg       <= S_INIT_SET;
                    end
                    else if (req.valid)
                    begin
                        granted_reg <= '0;
                        status_reg  <= ST_OK;
                        ord_reg     <= req_ord;
                        page_reg    <= req.page;
                        if (req_bad)
                        begin
                            status_reg <= ST_INVALID;
                            state_reg  <= S_DONE;
                        end
                        else if (req.cmd == CMD_ALLOC)
                        begin
                            if (!fnd || (32'(cnt_reg) + 32'd1 < 32'(fnd_ord - req_ord)))
                            begin
                                status_reg <= ST_NOMEM;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                a_reg     <= fnd_ord;
                                state_reg <= S_PH_RD;
                                if (32'(fpt_reg) >= (32'd1 << req_ord))
                                    fpt_reg <= fpt_reg - cnt_t'(32'd1 << req_ord);
                                else
                                    fpt_reg <= '0;
                            end
                        end
                        else if (cnt_reg == '0)
                        begin
                            status_reg <= ST_NOMEM;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            a_reg         <= req_ord;
                            app_ord_reg   <= req_ord;
                            app_start_reg <= req.page;
                            ret_reg       <= S_FR_LOOP;
                            state_reg     <= S_AP_REQ;
                            if (32'(fpt_reg) + (32'd1 << req_ord) > 32'(SLOTS_C))
                                fpt_reg <= SLOTS_C;
                            else
                                fpt_reg <= cnt_t'(32'(fpt_reg) + (32'd1 << req_ord));
                        end
                    end
                end

                // take the head of the chosen list
                S_PH_RD:
                begin
                    state_reg <= S_PH_USE;
                end
                S_PH_USE:
                begin
                    granted_reg     <= start_rd;
                    head_reg[a_reg] <= link_rd;
                    len_reg[a_reg]  <= cur_len - cnt_t'(1);
                    if (put_ok)
                        cnt_reg <= cnt_reg + cnt_t'(1);
                    state_reg <= S_SPLIT;
                end

                // hand right halves down one order at a time
                S_SPLIT:
                begin
                    if (a_reg > ord_reg)
                    begin
                        app_ord_reg   <= a_reg - oi_t'(1);
                        app_start_reg <= granted_reg + (pg_t'(1) << (a_reg - oi_t'(1)));
                        a_reg         <= a_reg - oi_t'(1);
                        ret_reg       <= S_SPLIT;
                        state_reg     <= S_AP_REQ;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                // merge loop
                S_FR_LOOP:
                begin
                    if (32'(a_reg) >= MAX_ORDER_P)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        tgt_reg   <= buddy_of(page_reg, a_reg);
                        pass_reg  <= 1'b0;
                        state_reg <= S_RM_START;
                    end
                end

                // walk a list for the first entry matching the target
                S_RM_START:
                begin
                    cur_reg   <= head_reg[a_reg];
                    prev_reg  <= '0;
                    k_reg     <= '0;
                    state_reg <= S_RM_RD;
                end
                S_RM_RD:
                begin
                    if (k_reg >= cur_len)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RM_CHK;
                end
                S_RM_CHK:
                begin
                    if (hit)
                    begin
                        if (k_reg == '0)
                            head_reg[a_reg] <= link_rd;
                        if (k_reg + cnt_t'(1) == cur_len)
                            tail_reg[a_reg] <= prev_reg;
                        len_reg[a_reg] <= cur_len - cnt_t'(1);
                        if (put_ok)
                            cnt_reg <= cnt_reg + cnt_t'(1);
                        if (!pass_reg)
                        begin
                            tgt_reg   <= buddy_of(tgt_reg, a_reg);
                            pass_reg  <= 1'b1;
                            state_reg <= S_RM_START;
                        end
                        else
                        begin
                            if ((page_reg & ((pg_t'(2) << a_reg) - pg_t'(1))) != '0)
                            begin
                                page_reg      <= page_reg - (pg_t'(1) << a_reg);
                                app_start_reg <= page_reg - (pg_t'(1) << a_reg);
                            end
                            else
                            begin
                                app_start_reg <= page_reg;
                            end
                            app_ord_reg <= a_reg + oi_t'(1);
                            a_reg       <= a_reg + oi_t'(1);
                            ret_reg     <= S_FR_LOOP;
                            state_reg   <= S_AP_REQ;
                        end
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= link_rd;
                        k_reg     <= k_reg + cnt_t'(1);
                        state_reg <= S_RM_RD;
                    end
                end

                // append: take a spare slot, link it at the tail
                S_AP_REQ:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        cnt_reg    <= cnt_reg - cnt_t'(1);
                        virgin_reg <= (cnt_reg - cnt_t'(1) < min_cnt_reg);
                        if (cnt_reg - cnt_t'(1) < min_cnt_reg)
                            min_cnt_reg <= cnt_reg - cnt_t'(1);
                        state_reg <= S_AP_WAIT;
                    end
                end
                S_AP_WAIT:
                begin
                    slot_reg  <= slot_w;
                    state_reg <= S_AP_SET;
                end
                S_AP_SET:
                begin
                    if (app_len == '0)
                        head_reg[app_ord_reg] <= slot_reg;
                    tail_reg[app_ord_reg] <= slot_reg;
                    len_reg[app_ord_reg]  <= app_len + cnt_t'(1);
                    state_reg             <= ret_reg;
                end

                // hand the result to the output register
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= status_reg;
                        out_granted_reg <= granted_reg;
                        out_fpt_reg     <= fpt_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bpa_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
